// ===== hdl/ewman_pkg.sv =====
`timescale 1ns / 1ps

package ewman_pkg;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned STD_W     = SAMPLE_W - 1;
  localparam int unsigned MEAN_X    = 16;
  localparam int unsigned MEAN_W    = SAMPLE_W + MEAN_X;
  localparam int unsigned VAR_W     = 48;
  localparam int unsigned ALPHA_W   = 32;
  localparam int unsigned OPER_W    = 64;
  localparam int unsigned DEN_W     = 32;
  localparam int unsigned ROOT_W    = VAR_W / 2;
  localparam int unsigned STEP_W    = 7;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 32'd214748365;
  localparam logic [STD_W-1:0]   ONE_VOLT  = STD_W'(1 << 19);
  localparam logic [STD_W-1:0]   STD_MAX   = {STD_W{1'b1}};
  localparam logic [VAR_W-1:0]   VAR_MAX   = {VAR_W{1'b1}};

  localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(OPER_W);
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(OPER_W);
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(ROOT_W);

  typedef enum logic [1:0] {
    ARITH_NONE,
    ARITH_MUL,
    ARITH_DIV,
    ARITH_SQRT
  } arith_e;

  typedef enum logic [3:0] {
    OP_SEED_ONE,
    OP_ONE_MEAN,
    OP_ONE_TERM,
    OP_VAR_BLEND,
    OP_SQRT,
    OP_FMEAN,
    OP_X2,
    OP_SEED_M2,
    OP_BLEND_MEAN,
    OP_M2,
    OP_NORM
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LAUNCH,
    ST_WAIT,
    ST_READ,
    ST_NLAUNCH,
    ST_NWAIT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic start;
    logic commit;
    op_e  op;
    logic rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic seeded;
    logic n_one;
    logic k_last;
    logic out_free;
  } stat_t;

  function automatic logic [OPER_W-1:0] mag64(input logic [OPER_W-1:0] v);
    return v[OPER_W-1] ? (~v + OPER_W'(1)) : v;
  endfunction

endpackage

// ===== hdl/ewman_ram.sv =====
`timescale 1ns / 1ps

module ewman_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ewman_arith.sv =====
`timescale 1ns / 1ps

module ewman_arith import ewman_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  arith_e              kind_i,
  input  logic [OPER_W-1:0]   opa_i,
  input  logic [OPER_W-1:0]   opb_i,
  output logic                busy_o,
  output logic [2*OPER_W-1:0] prod_o,
  output logic [OPER_W-1:0]   quo_o,
  output logic [ROOT_W-1:0]   root_o
);

  logic                busy_q, busy_d;
  arith_e              kind_q, kind_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [OPER_W-1:0]   hi_q, hi_d, lo_q, lo_d, mc_q, mc_d;
  logic [DEN_W-1:0]    rem_q, rem_d, den_q, den_d;
  logic [VAR_W-1:0]    v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic [OPER_W:0]     mul_sum;
  logic [DEN_W:0]      div_sh;
  logic                div_ge;
  logic [VAR_W:0]      sq_try;

  always_comb begin
    mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);
    div_sh  = {rem_q, lo_q[OPER_W-1]};
    div_ge  = div_sh >= {1'b0, den_q};
    sq_try  = {1'b0, r_q} + {1'b0, bit_q};
  end

  always_comb begin
    busy_d = busy_q;
    kind_d = kind_q;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    mc_d   = mc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    if (start_i) begin
      kind_d = kind_i;
      busy_d = (kind_i != ARITH_NONE);
      case (kind_i)
        ARITH_MUL: begin
          hi_d  = '0;
          lo_d  = opb_i;
          mc_d  = opa_i;
          cnt_d = MUL_STEPS - STEP_W'(1);
        end
        ARITH_DIV: begin
          rem_d = '0;
          lo_d  = opa_i;
          den_d = opb_i[DEN_W-1:0];
          cnt_d = DIV_STEPS - STEP_W'(1);
        end
        ARITH_SQRT: begin
          v_d   = opa_i[VAR_W-1:0];
          r_d   = '0;
          bit_d = VAR_W'(1) << (VAR_W - 2);
          cnt_d = SQRT_STEPS - STEP_W'(1);
        end
        default: begin
          cnt_d = '0;
        end
      endcase
    end else if (busy_q) begin
      case (kind_q)
        ARITH_MUL: begin
          hi_d = mul_sum[OPER_W:1];
          lo_d = {mul_sum[0], lo_q[OPER_W-1:1]};
        end
        ARITH_DIV: begin
          rem_d = div_ge ? DEN_W'(div_sh - {1'b0, den_q}) : div_sh[DEN_W-1:0];
          lo_d  = {lo_q[OPER_W-2:0], div_ge};
        end
        ARITH_SQRT: begin
          if ({1'b0, v_q} >= sq_try) begin
            v_d = VAR_W'({1'b0, v_q} - sq_try);
            r_d = (r_q >> 1) + bit_q;
          end else begin
            r_d = r_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= ARITH_NONE;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    mc_q  <= mc_d;
    rem_q <= rem_d;
    den_q <= den_d;
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign busy_o = busy_q;
  assign prod_o = {hi_q, lo_q};
  assign quo_o  = lo_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

// ===== hdl/ewman_dp.sv =====
`timescale 1ns / 1ps

module ewman_dp import ewman_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wen_i,
  input  logic [ALPHA_W-1:0]  cfg_wdata_i,
  input  logic                in_acc_i,
  input  logic [SAMPLE_W-1:0] in_sample_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [SAMPLE_W-1:0] out_norm_o,
  output logic [SAMPLE_W-1:0] out_mean_o,
  output logic [STD_W-1:0]    out_stdev_o,
  output logic                out_last_o,
  output logic                out_sat_o
);

  localparam int unsigned CW    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned SUM_W = SAMPLE_W + CW;
  localparam int unsigned SQ_W  = 2 * SAMPLE_W - 1 + CW;

  logic [ALPHA_W-1:0]       alpha_q;
  logic                     seeded_q;
  logic signed [MEAN_W-1:0] mean_q, fmean_q;
  logic [VAR_W-1:0]         var_q, tmp_q;
  logic [STD_W-1:0]         stdev_q;
  logic [CW-1:0]            cnt_q;
  logic [AW-1:0]            k_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]          sq_q;
  logic [OPER_W-1:0]        x2_q;
  logic signed [OPER_W-1:0] d_q, d_new;

  logic                     out_valid_q;
  logic [SAMPLE_W-1:0]      out_norm_q, out_mean_q;
  logic [STD_W-1:0]         out_stdev_q;
  logic                     out_last_q, out_sat_q;

  logic [SAMPLE_W-1:0]      rdata;
  logic                     busy;
  logic [2*OPER_W-1:0]      prod;
  logic [OPER_W-1:0]        quo;
  logic [ROOT_W-1:0]        root;
  arith_e                   kind;
  logic [OPER_W-1:0]        opa, opb;

  logic signed [OPER_W-1:0] sum64, mean64, xs64, x64, fmean64;
  logic [OPER_W-1:0]        step, n64;
  logic [VAR_W:0]           r49;
  logic [VAR_W-1:0]         m2sat, seed_var, m2_diff;
  logic [SAMPLE_W-1:0]      in_mag;
  logic [2*SAMPLE_W-1:0]    in_sq;
  logic                     room;
  logic [MEAN_W-1:0]        mean_mag;
  logic [MEAN_W-MEAN_X:0]   ms;
  logic [SAMPLE_W-1:0]      mean_s;
  logic [SAMPLE_W-1:0]      norm_v;
  logic                     norm_sat;

  ewman_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_CHANNELS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (in_acc_i && room),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(in_sample_i),
    .re_i   (cmd_i.rd),
    .raddr_i(k_q),
    .rdata_o(rdata)
  );

  ewman_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.start),
    .kind_i (kind),
    .opa_i  (opa),
    .opb_i  (opb),
    .busy_o (busy),
    .prod_o (prod),
    .quo_o  (quo),
    .root_o (root)
  );

  always_comb begin
    room    = cnt_q < CW'(MAX_CHANNELS);
    in_mag  = in_sample_i[SAMPLE_W-1] ? (~in_sample_i + SAMPLE_W'(1)) : in_sample_i;
    in_sq   = in_mag * in_mag;
    sum64   = OPER_W'(sum_q);
    mean64  = OPER_W'(mean_q);
    fmean64 = OPER_W'(fmean_q);
    xs64    = sum64 <<< MEAN_X;
    x64     = OPER_W'($signed(rdata)) <<< MEAN_X;
    n64     = OPER_W'(cnt_q);
    step    = prod[95:32] + OPER_W'(prod[31]);
    r49     = {1'b0, prod[79:32]} + (VAR_W + 1)'(prod[31]);
    if (prod[127:80] != '0 || r49[VAR_W]) begin
      m2sat = VAR_MAX;
    end else begin
      m2sat = r49[VAR_W-1:0];
    end
    if (x2_q > OPER_W'(m2sat)) begin
      seed_var = ((x2_q - OPER_W'(m2sat)) > OPER_W'(VAR_MAX)) ? VAR_MAX
               : VAR_W'(x2_q - OPER_W'(m2sat));
      m2_diff  = seed_var;
    end else begin
      seed_var = '0;
      m2_diff  = VAR_W'(OPER_W'(m2sat) - x2_q);
    end
  end

  always_comb begin
    kind  = ARITH_NONE;
    opa   = '0;
    opb   = '0;
    d_new = d_q;
    case (cmd_i.op)
      OP_ONE_MEAN: begin
        d_new = xs64 - mean64;
        kind  = ARITH_MUL;
        opa   = mag64(d_new);
        opb   = OPER_W'(alpha_q);
      end
      OP_ONE_TERM: begin
        kind = ARITH_MUL;
        opa  = mag64(d_q);
        opb  = mag64(xs64 - mean64);
      end
      OP_VAR_BLEND: begin
        d_new = OPER_W'(tmp_q) - OPER_W'(var_q);
        kind  = ARITH_MUL;
        opa   = mag64(d_new);
        opb   = OPER_W'(alpha_q);
      end
      OP_SQRT: begin
        kind = ARITH_SQRT;
        opa  = OPER_W'(var_q);
      end
      OP_FMEAN: begin
        kind = ARITH_DIV;
        opa  = (mag64(sum64) << MEAN_X) + (n64 >> 1);
        opb  = n64;
      end
      OP_X2: begin
        kind = ARITH_DIV;
        opa  = OPER_W'(sq_q) + (n64 >> 1);
        opb  = n64;
      end
      OP_SEED_M2: begin
        kind = ARITH_MUL;
        opa  = mag64(fmean64);
        opb  = mag64(fmean64);
      end
      OP_BLEND_MEAN: begin
        d_new = fmean64 - mean64;
        kind  = ARITH_MUL;
        opa   = mag64(d_new);
        opb   = OPER_W'(alpha_q);
      end
      OP_M2: begin
        kind = ARITH_MUL;
        opa  = mag64(mean64);
        opb  = mag64(mean64);
      end
      OP_NORM: begin
        d_new = x64 - mean64;
        kind  = ARITH_DIV;
        opa   = mag64(d_new) + OPER_W'(stdev_q);
        opb   = OPER_W'({stdev_q, 1'b0});
      end
      default: begin
        kind = ARITH_NONE;
      end
    endcase
  end

  always_comb begin
    mean_mag = mean_q[MEAN_W-1] ? (~mean_q + MEAN_W'(1)) : mean_q;
    ms       = (MEAN_W - MEAN_X + 1)'(({1'b0, mean_mag} + (MEAN_W + 1)'(1 << (MEAN_X - 1)))
               >> MEAN_X);
    if (mean_q[MEAN_W-1]) begin
      mean_s = (ms > (MEAN_W - MEAN_X + 1)'(1 << (SAMPLE_W - 1)))
             ? {1'b1, {(SAMPLE_W-1){1'b0}}} : SAMPLE_W'(~ms + 1'b1);
    end else begin
      mean_s = (ms > (MEAN_W - MEAN_X + 1)'(STD_MAX))
             ? {1'b0, STD_MAX} : SAMPLE_W'(ms);
    end
    norm_sat = 1'b0;
    if (stdev_q == '0) begin
      norm_sat = 1'b1;
      if (d_q == '0) begin
        norm_v = '0;
      end else if (d_q[OPER_W-1]) begin
        norm_v = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        norm_v = {1'b0, STD_MAX};
      end
    end else if (d_q[OPER_W-1]) begin
      if (quo > OPER_W'(1 << (SAMPLE_W - 1))) begin
        norm_v   = {1'b1, {(SAMPLE_W-1){1'b0}}};
        norm_sat = 1'b1;
      end else begin
        norm_v = SAMPLE_W'(~quo + OPER_W'(1));
      end
    end else begin
      if (quo > OPER_W'(STD_MAX)) begin
        norm_v   = {1'b0, STD_MAX};
        norm_sat = 1'b1;
      end else begin
        norm_v = SAMPLE_W'(quo);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= ALPHA_RST;
      seeded_q    <= 1'b0;
      mean_q      <= '0;
      fmean_q     <= '0;
      var_q       <= '0;
      tmp_q       <= '0;
      x2_q        <= '0;
      stdev_q     <= ONE_VOLT;
      cnt_q       <= '0;
      k_q         <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wen_i) begin
        alpha_q <= cfg_wdata_i;
      end
      if (in_acc_i && room) begin
        sum_q <= sum_q + SUM_W'($signed(in_sample_i));
        sq_q  <= sq_q + SQ_W'(in_sq);
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.commit) begin
        case (cmd_i.op)
          OP_SEED_ONE: begin
            mean_q   <= MEAN_W'(xs64);
            var_q    <= '0;
            stdev_q  <= ONE_VOLT;
            seeded_q <= 1'b1;
          end
          OP_ONE_MEAN, OP_BLEND_MEAN: begin
            mean_q <= d_q[OPER_W-1] ? mean_q - MEAN_W'(step) : mean_q + MEAN_W'(step);
          end
          OP_ONE_TERM: begin
            tmp_q <= m2sat;
          end
          OP_VAR_BLEND: begin
            var_q <= d_q[OPER_W-1] ? var_q - VAR_W'(step) : var_q + VAR_W'(step);
          end
          OP_SQRT: begin
            stdev_q <= root[ROOT_W-1] ? STD_MAX : root[STD_W-1:0];
          end
          OP_FMEAN: begin
            fmean_q <= sum_q[SUM_W-1] ? MEAN_W'(~quo + OPER_W'(1)) : MEAN_W'(quo);
          end
          OP_X2: begin
            x2_q <= quo;
          end
          OP_SEED_M2: begin
            mean_q   <= fmean_q;
            var_q    <= seed_var;
            seeded_q <= 1'b1;
          end
          OP_M2: begin
            tmp_q <= m2_diff;
          end
          default: begin
            tmp_q <= tmp_q;
          end
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (stat_o.k_last) begin
          k_q   <= '0;
          cnt_q <= '0;
          sum_q <= '0;
          sq_q  <= '0;
        end else begin
          k_q <= k_q + AW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      d_q <= d_new;
    end
    if (cmd_i.emit) begin
      out_norm_q  <= norm_v;
      out_mean_q  <= mean_s;
      out_stdev_q <= stdev_q;
      out_last_q  <= stat_o.k_last;
      out_sat_q   <= norm_sat;
    end
  end

  always_comb begin
    stat_o.busy     = busy;
    stat_o.seeded   = seeded_q;
    stat_o.n_one    = (cnt_q == CW'(1));
    stat_o.k_last   = (CW'(k_q) == cnt_q - CW'(1));
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_norm_o  = out_norm_q;
  assign out_mean_o  = out_mean_q;
  assign out_stdev_o = out_stdev_q;
  assign out_last_o  = out_last_q;
  assign out_sat_o   = out_sat_q;

endmodule

// ===== hdl/ewman_ctrl.sv =====
`timescale 1ns / 1ps

module ewman_ctrl import ewman_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_acc_i,
  input  logic  in_last_i,
  input  logic  in_upd_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  function automatic op_e next_op(input op_e op, input logic seeded);
    op_e r;
    r = OP_SQRT;
    case (op)
      OP_ONE_MEAN:   r = OP_ONE_TERM;
      OP_ONE_TERM:   r = OP_VAR_BLEND;
      OP_VAR_BLEND:  r = OP_SQRT;
      OP_FMEAN:      r = OP_X2;
      OP_X2:         r = seeded ? OP_BLEND_MEAN : OP_SEED_M2;
      OP_SEED_M2:    r = OP_SQRT;
      OP_BLEND_MEAN: r = OP_M2;
      OP_M2:         r = OP_VAR_BLEND;
      default:       r = OP_SQRT;
    endcase
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc_i && in_last_i) begin
          state_d = in_upd_i ? ST_START : ST_READ;
        end
      end
      ST_START: begin
        if (stat_i.n_one) begin
          op_d = stat_i.seeded ? OP_ONE_MEAN : OP_SEED_ONE;
        end else begin
          op_d = OP_FMEAN;
        end
        state_d = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (!stat_i.busy) begin
          if (op_q == OP_SQRT || op_q == OP_SEED_ONE) begin
            state_d = ST_READ;
          end else begin
            op_d    = next_op(op_q, stat_i.seeded);
            state_d = ST_LAUNCH;
          end
        end
      end
      ST_READ: begin
        state_d = ST_NLAUNCH;
      end
      ST_NLAUNCH: begin
        state_d = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (!stat_i.busy && stat_i.out_free) begin
          state_d = stat_i.k_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = op_q;
    cmd_o.in_ready = (state_q == ST_IDLE);
    case (state_q)
      ST_LAUNCH: begin
        cmd_o.start = 1'b1;
      end
      ST_WAIT: begin
        cmd_o.commit = !stat_i.busy;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      ST_NLAUNCH: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_NORM;
      end
      ST_NWAIT: begin
        cmd_o.op   = OP_NORM;
        cmd_o.emit = !stat_i.busy && stat_i.out_free;
      end
      default: begin
        cmd_o.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SEED_ONE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ===== hdl/ewma_mean_variance_normalizer.sv =====
// Input: a sample that does not close a frame is taken while the block is idle.
// A closing sample with update first runs the statistics (each multiply, divide and
// square root in the shared iterative arithmetic unit), then one normalizing divide per
// channel result in the 64-step divider.
// Throughput: one frame at a time; input is held off from the closing transfer until
// the last result is loaded. Reset clears statistics (stdev to ONE_VOLT) and frame counters, alpha to default.
`timescale 1ns / 1ps

module ewma_mean_variance_normalizer import ewman_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wen_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  logic [23:0]   s_tdata_i,   // sample
  input  logic          s_tlast_i,
  input  logic [0:0]    s_tuser_i,   // do_update
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [71:0]   m_tdata_o,   // normalized, mean_out, stdev_out, zero pad
  output logic          m_tlast_o,
  output logic [0:0]    m_tuser_o    // saturated
);

  cmd_t                cmd;
  stat_t               stat;
  logic                in_acc;
  logic [SAMPLE_W-1:0] norm, mean;
  logic [STD_W-1:0]    stdev;
  logic                sat;

  assign in_acc     = s_tvalid_i && cmd.in_ready;
  assign s_tready_o = cmd.in_ready;

  ewman_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_acc_i (in_acc),
    .in_last_i(s_tlast_i),
    .in_upd_i (s_tuser_i[0]),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  ewman_dp #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wen_i  (cfg_wen_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_acc_i   (in_acc),
    .in_sample_i(s_tdata_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_ready_i(m_tready_i),
    .out_valid_o(m_tvalid_o),
    .out_norm_o (norm),
    .out_mean_o (mean),
    .out_stdev_o(stdev),
    .out_last_o (m_tlast_o),
    .out_sat_o  (sat)
  );

  assign m_tdata_o = {1'b0, stdev, mean, norm};
  assign m_tuser_o = sat;

endmodule

// ===== hdl/ewman_chk.sv =====
`timescale 1ns / 1ps

module ewman_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        s_tlast_i,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [71:0] m_tdata_o,
  input logic        m_tlast_o,
  input logic [0:0]  m_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("result changed while stalled");

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o && s_tlast_i |=> !s_tready_o)
    else $error("input taken right after frame close");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tlast_o |-> !s_tready_o)
    else $error("input taken in the middle of a frame's results");

  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tdata_o[70:48] == 23'd0) |-> m_tuser_o[0])
    else $error("zero stdev not flagged");

endmodule

bind ewma_mean_variance_normalizer ewman_chk u_chk (.*);

// ===== tb/ewma_mean_variance_normalizer_tb.sv =====
`timescale 1ns / 1ps

class norm_scoreboard;
  bit [31:0]   alpha;
  bit          seeded;
  logic signed [63:0] run_mean;
  logic [63:0] run_var;
  logic [63:0] run_std;
  logic signed [63:0] fstore [16];
  int          fcount;
  logic signed [63:0] fsum;
  logic [63:0] fsq;
  logic [71:0] exp_data [$];
  bit          exp_last [$];
  bit          exp_sat [$];
  int          errors;
  int          checked;

  function new();
    alpha = 32'd214748365;
    seeded = 0;
    run_mean = 0;
    run_var = 0;
    run_std = 64'd524288;
    fcount = 0;
    fsum = 0;
    fsq = 0;
    errors = 0;
    checked = 0;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] mul32(logic [63:0] a, logic [63:0] b, bit sat);
    logic [127:0] p;
    logic [127:0] r;
    p = a * b;
    r = (p >> 32) + p[31];
    if (sat && r > 128'hFFFF_FFFF_FFFF) return 64'hFFFF_FFFF_FFFF;
    return r[63:0];
  endfunction

  function automatic logic signed [63:0] blend(logic signed [63:0] old,
                                              logic signed [63:0] tgt);
    logic signed [63:0] d;
    logic [63:0] st;
    d = tgt - old;
    st = mul32(mag(d), {32'd0, alpha}, 0);
    return d < 0 ? old - $signed(st) : old + $signed(st);
  endfunction

  function automatic logic [63:0] clamp_var(logic signed [63:0] v);
    if (v < 0) return 0;
    return v > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : v;
  endfunction

  function automatic logic signed [63:0] rdiv(logic signed [63:0] num, logic [63:0] den);
    logic [63:0] q;
    q = (mag(num) + den / 2) / den;
    return num < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic void set_std();
    logic [63:0] v, r, b;
    v = run_var;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    run_std = r > 64'h7F_FFFF ? 64'h7F_FFFF : r;
  endfunction

  function automatic void update_one(logic signed [63:0] x);
    logic signed [63:0] xs, old;
    logic [63:0] term;
    xs = x <<< 16;
    old = run_mean;
    if (!seeded) begin
      run_mean = xs;
      run_var = 0;
      run_std = 64'd524288;
      seeded = 1;
      return;
    end
    run_mean = blend(old, xs);
    term = mul32(mag(xs - old), mag(xs - run_mean), 1);
    run_var = clamp_var(blend($signed(run_var), $signed(term)));
    set_std();
  endfunction

  function automatic void update_batch(int n);
    logic signed [63:0] fm;
    logic [63:0] x2, m2;
    fm = rdiv(fsum <<< 16, n);
    x2 = (fsq + n / 2) / n;
    if (!seeded) begin
      run_mean = fm;
      m2 = mul32(mag(fm), mag(fm), 1);
      run_var = x2 > m2 ? ((x2 - m2) > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : x2 - m2) : 0;
      set_std();
      seeded = 1;
      return;
    end
    run_mean = blend(run_mean, fm);
    m2 = mul32(mag(run_mean), mag(run_mean), 1);
    m2 = x2 > m2 ? x2 - m2 : m2 - x2;
    if (m2 > 64'hFFFF_FFFF_FFFF) m2 = 64'hFFFF_FFFF_FFFF;
    run_var = clamp_var(blend($signed(run_var), $signed(m2)));
    set_std();
  endfunction

  function automatic void note_sample(logic [23:0] s, bit last, bit upd);
    logic signed [63:0] x, ms, d, q;
    bit sat;
    x = $signed(s);
    if (fcount < 16) begin
      fstore[fcount] = x;
      fsum = fsum + x;
      fsq = fsq + mag(x) * mag(x);
      fcount++;
    end
    if (!last) return;
    if (upd) begin
      if (fcount == 1) update_one(fstore[0]);
      else update_batch(fcount);
    end
    ms = rdiv(run_mean, 64'd65536);
    if (ms > 8388607) ms = 8388607;
    if (ms < -8388608) ms = -8388608;
    for (int k = 0; k < fcount; k++) begin
      d = (fstore[k] <<< 16) - run_mean;
      sat = 0;
      if (run_std == 0) begin
        sat = 1;
        q = d > 0 ? 8388607 : (d < 0 ? -8388608 : 0);
      end else begin
        q = rdiv(d, 2 * run_std);
        if (q > 8388607) begin q = 8388607; sat = 1; end
        if (q < -8388608) begin q = -8388608; sat = 1; end
      end
      exp_data.push_back({1'b0, run_std[22:0], ms[23:0], q[23:0]});
      exp_last.push_back(k + 1 == fcount);
      exp_sat.push_back(sat);
    end
    fcount = 0;
    fsum = 0;
    fsq = 0;
  endfunction

  function automatic void check_result(logic [71:0] d, logic l, logic s);
    if (exp_data.size() == 0) begin
      $display("%0t: unexpected result data=%h last=%b sat=%b", $realtime, d, l, s);
      errors++;
      return;
    end
    checked++;
    if (d[23:0] !== exp_data[0][23:0])
      $display("%0t: normalized expected %h actual %h", $realtime, exp_data[0][23:0], d[23:0]);
    if (d[47:24] !== exp_data[0][47:24])
      $display("%0t: mean expected %h actual %h", $realtime, exp_data[0][47:24], d[47:24]);
    if (d[70:48] !== exp_data[0][70:48])
      $display("%0t: stdev expected %h actual %h", $realtime, exp_data[0][70:48], d[70:48]);
    if (l !== exp_last[0])
      $display("%0t: last expected %b actual %b", $realtime, exp_last[0], l);
    if (s !== exp_sat[0])
      $display("%0t: saturated expected %b actual %b", $realtime, exp_sat[0], s);
    if (d[70:0] !== exp_data[0][70:0] || l !== exp_last[0] || s !== exp_sat[0]) errors++;
    void'(exp_data.pop_front());
    void'(exp_last.pop_front());
    void'(exp_sat.pop_front());
  endfunction
endclass

module ewma_mean_variance_normalizer_tb;
  import ewman_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_wen_i = 0;
  logic [31:0] cfg_wdata_i = 0;
  logic        s_tvalid_i = 0;
  logic        s_tready_o;
  logic [23:0] s_tdata_i = 0;
  logic        s_tlast_i = 0;
  logic [0:0]  s_tuser_i = 0;
  logic        m_tvalid_o;
  logic        m_tready_i = 0;
  logic [71:0] m_tdata_o;
  logic        m_tlast_o;
  logic [0:0]  m_tuser_o;

  norm_scoreboard sb = new();
  int  hold_off = 0;
  bit  drain_done = 0;
  int  n_items = 0;
  int  n_frames = 0;

  ewma_mean_variance_normalizer u_top (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i)
    if (rst_ni && m_tvalid_o && m_tready_i) sb.check_result(m_tdata_o, m_tlast_o, m_tuser_o);

  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        m_tready_i <= 0;
        hold_off--;
      end else if (m_tready_i && m_tvalid_o) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
          m_tready_i <= 0;
          repeat (gap) @(negedge clk_i);
          m_tready_i <= 1;
        end
      end else begin
        m_tready_i <= 1;
      end
    end
  end

  task automatic send_sample(logic [23:0] s, bit last, bit upd, bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0) : 0;
    if (gap > 0) begin
      s_tvalid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1;
    s_tdata_i <= s;
    s_tlast_i <= last;
    s_tuser_i <= upd;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_sample(s, last, upd);
    n_items++;
    if (last) n_frames++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid_i <= 0;
    while (sb.exp_data.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task automatic write_alpha(logic [31:0] a);
    drain();
    cfg_wen_i <= 1;
    cfg_wdata_i <= a;
    @(negedge clk_i);
    cfg_wen_i <= 0;
    sb.alpha = a;
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 4000)) - 24'd2000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_frame(int n, bit upd, bit gaps);
    for (int i = 0; i < n; i++) send_sample(rand_sample(), i == n - 1, upd, gaps);
  endtask

  initial begin
    logic [31:0] alphas [5];
    alphas = '{32'd1, 32'h8000_0000, 32'd0, 32'h4000_0000, 32'hFFFF_FFFF};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: seed by a single channel, then extremes, zero stdev, overflow
    send_sample(24'h000100, 1, 1, 0);
    send_sample(24'h7FFFFF, 1, 0, 0);
    send_sample(24'h800000, 1, 0, 0);
    send_sample(24'h000100, 1, 1, 0);
    send_sample(24'h7FFFFF, 0, 0, 0);
    send_sample(24'h800000, 0, 1, 0);
    send_sample(24'h000000, 1, 1, 0);
    send_sample(24'h123456, 1, 1, 0);
    for (int i = 0; i < 18; i++) send_sample(24'(i * 1000), i == 17, 1, 0);
    write_alpha(32'h8000_0000);
    send_frame(4, 1, 1);
    send_frame(1, 1, 1);
    // block fills up while the receiver holds off
    hold_off = 3000;
    send_frame(16, 1, 0);
    send_frame(3, 1, 0);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_alpha(alphas[p]);
      for (int f = 0; f < 18; f++) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 18) : $urandom_range(1, 5);
        send_frame(n, $urandom_range(0, 3) != 0, 1);
      end
    end
    write_alpha($urandom);
    while (n_items < 460) send_frame($urandom_range(1, 6), $urandom_range(0, 1), 1);
    drain_done = 1;
    drain();
    $display("fed %0d samples in %0d frames, checked %0d results", n_items, n_frames,
             sb.checked);
    $display("covered alpha extremes, frame overflow, seeding and output back-pressure");
    if (sb.errors == 0 && sb.exp_data.size() == 0) begin
      $display("ewma_mean_variance_normalizer_tb: clean");
    end else begin
      $display("ewma_mean_variance_normalizer_tb: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("ewma_mean_variance_normalizer_tb: errors");
    $finish;
  end
endmodule
